@@ rtl/core/link_choice_by_history_and_signal_defines.svh @@
// ----------------------------------------------------------------------------
// Link choice assertion macros
// Concurrent check helpers shared by the link choice block.
// ----------------------------------------------------------------------------
`ifndef LINK_CHOICE_BY_HISTORY_AND_SIGNAL_DEFINES_SVH
`define LINK_CHOICE_BY_HISTORY_AND_SIGNAL_DEFINES_SVH

// same-cycle implication
`define LCBHS_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LCBHS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/lcbhs_pkg.sv @@
// ----------------------------------------------------------------------------
// Link choice package
// Codes, fixed point constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lcbhs_pkg;

	localparam logic [1:0] KIND_REPORT = 2'd0;
	localparam logic [1:0] KIND_SELECT = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic [2:0] MODE_WIFI   = 3'd0;
	localparam logic [2:0] MODE_BLE    = 3'd1;
	localparam logic [2:0] MODE_LAST   = 3'd2;
	localparam logic [2:0] MODE_FAST   = 3'd3;
	localparam logic [2:0] MODE_STRONG = 3'd4;
	localparam logic [2:0] MODE_ADAPT  = 3'd5;
	localparam logic [2:0] MODE_RESET  = MODE_ADAPT;

	localparam logic LINK_WIFI = 1'b0;
	localparam logic LINK_BLE  = 1'b1;

	localparam int unsigned DIV_STEPS = 22;
	localparam int unsigned SCORE_W   = 24;

	localparam logic [31:0] WIN_SHORT = 32'd300000;
	localparam logic [31:0] WIN_LONG  = 32'd3600000;

	// Q6.16 term values
	localparam logic [21:0] SHARE_CAP = 22'd2621440;
	localparam logic [21:0] REC_SHORT = 22'd1966080;
	localparam logic [21:0] REC_LONG  = 22'd983040;
	localparam logic [21:0] SIG_CAP   = 22'd1310720;

	localparam logic signed [7:0] SIG_ABSENT = -8'sd1;
	localparam logic signed [7:0] SIG_FLOOR  = -8'sd100;
	localparam logic signed [8:0] SIG_OFFSET = 9'sd100;
	localparam logic signed [8:0] SIG_KNEE   = 9'sd70;

	// x*2^17/7 = x*18724 + floor(4x/7); 4x/7 by reciprocal 2341/2^14
	localparam logic [14:0] SIG_MUL  = 15'd18724;
	localparam logic [11:0] SIG_RMUL = 12'd2341;
	localparam int unsigned SIG_RSH  = 14;

	// d*2^16/1000 = d*65 + floor(67d/125); /125 by reciprocal over 2^27
	localparam logic [15:0] MEAN_LIMIT = 16'd10000;
	localparam logic [6:0]  SPD_MUL    = 7'd65;
	localparam logic [6:0]  SPD_RES    = 7'd67;
	localparam logic [20:0] SPD_RCP    = 21'd1073742;
	localparam int unsigned SPD_SH     = 27;

	// /10 by reciprocal over 2^23
	localparam logic [19:0] MEAN_RCP = 20'd838861;
	localparam int unsigned MEAN_SH  = 23;

	typedef struct packed {
		logic latch;
		logic rep_calc;
		logic rep_write;
		logic clear;
		logic div_start;
		logic sel;
		logic term;
		logic speed;
		logic sum;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       need_score;
		logic       div_busy;
	} sts_t;

endpackage

@@ rtl/core/link_choice_by_history_and_signal.sv @@
// ----------------------------------------------------------------------------
// Link choice by history and signal
// Keeps attempt/success history for wifi and ble and picks a link on request.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          content
//  s_*       in   tvalid/tready      report, select or clear item
//  m_*       out  tvalid/tready      primary and secondary link
//  cfg_*     in   cfg_wen            strategy mode
//
//  Report: dispatch, average step and history write, then ready again;
//  clear acts in dispatch; select without scoring goes to the result register.
//  Adaptive select with both links seen: the serial share divider runs once
//  per link (22 steps each), each run followed by three term stages.
//  One item in work at a time; a pending result holds only the final load.
//  Asynchronous active-low reset clears history and sets adaptive mode.
// ----------------------------------------------------------------------------
`include "link_choice_by_history_and_signal_defines.svh"

module link_choice_by_history_and_signal (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// link, success, connect_time[15:0], wifi_found, wifi_dbm[7:0],
	// ble_found, ble_dbm[7:0], now_ms[31:0], zero pad
	input  logic [71:0] s_tdata,
	// kind[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// primary_link, secondary_link, zero pad
	output logic [7:0]  m_tdata,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_wdata
);

	lcbhs_pkg::cmd_t cmd;
	lcbhs_pkg::sts_t sts;
	logic            pick;

	lcbhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lcbhs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata[67:0]),
		.in_kind   (s_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.pick      (pick)
	);

	assign m_tdata = {6'b0, ~pick, pick};

	`LCBHS_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready,
		"transfer accepted while busy")
	`LCBHS_ASSERT_NOW(a_load_free, clk, arst_n, cmd.out_load, !m_tvalid || m_tready,
		"result overwritten")
	`LCBHS_ASSERT_NOW(a_div_adaptive, clk, arst_n, cmd.div_start,
		sts.need_score && (sts.kind == lcbhs_pkg::KIND_SELECT),
		"score run outside adaptive select")
	`LCBHS_ASSERT_NOW(a_rep_order, clk, arst_n, cmd.rep_write, $past(cmd.rep_calc),
		"report write without average step")

endmodule

@@ rtl/core/lcbhs_div.sv @@
// ----------------------------------------------------------------------------
// Link choice share divider
// Restoring divider, one quotient bit per cycle; initial remainder below den.
// ----------------------------------------------------------------------------
module lcbhs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] rem_init,
	input  logic [5:0]  low_bits,
	input  logic [31:0] den,
	output logic        busy,
	output logic [21:0] quo
);

	logic [31:0] rem_q;
	logic [21:0] low_q;
	logic [21:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        fit;

	assign trial = {rem_q, low_q[21]};
	assign diff  = trial - {1'b0, den};
	assign fit   = (trial >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(lcbhs_pkg::DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			low_q <= {low_bits, 16'b0};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fit ? diff[31:0] : trial[31:0];
			low_q <= {low_q[20:0], 1'b0};
			quo_q <= {quo_q[20:0], fit};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

@@ rtl/core/lcbhs_dp.sv @@
// ----------------------------------------------------------------------------
// Link choice datapath
// Item capture, per-link history, score terms and the link decision.
// ----------------------------------------------------------------------------
module lcbhs_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  lcbhs_pkg::cmd_t   cmd,
	output lcbhs_pkg::sts_t   sts,
	input  logic [67:0]       in_data,
	input  logic [1:0]        in_kind,
	input  logic              cfg_wen,
	input  logic [2:0]        cfg_wdata,
	output logic              pick
);

	logic [1:0]        kind_q;
	logic              link_q;
	logic              succ_q;
	logic [15:0]       ctime_q;
	logic signed [7:0] wsig_q;
	logic signed [7:0] bsig_q;
	logic [31:0]       now_q;
	logic [2:0]        mode_q;

	logic [31:0] succ_tot_q [2];
	logic [31:0] att_tot_q [2];
	logic [31:0] stamp_q [2];
	logic [15:0] mean_q [2];
	logic [lcbhs_pkg::SCORE_W-1:0] score_q [2];

	logic [19:0] rw_s1;
	logic [21:0] share_s1;
	logic [21:0] rec_s1;
	logic [21:0] sig_s1;
	logic [19:0] d65_s1;
	logic [19:0] d67_s1;
	logic [19:0] spd_s2;
	logic        pick_q;

	logic              idx;
	logic [31:0]       succ_sel;
	logic [31:0]       att_sel;
	logic [31:0]       stamp_sel;
	logic [15:0]       mean_sel;
	logic signed [7:0] sig_sel;
	logic              w_abs;
	logic              b_abs;
	logic              need_score;
	logic              quick;
	logic [37:0]       prod40;
	logic              div_busy;
	logic [21:0]       quo;
	logic [31:0]       age;
	logic signed [8:0] sx;
	logic [6:0]        x7;
	logic [21:0]       sig_int;
	logic [20:0]       sig_rp;
	logic [21:0]       sig_part;
	logic              spd_on;
	logic [13:0]       mean_gap;
	logic [40:0]       spd_prod;
	logic [39:0]       mean_prod;
	logic [15:0]       mean_new;

	assign idx       = (cmd.rep_calc || cmd.rep_write) ? link_q : cmd.sel;
	assign succ_sel  = succ_tot_q[idx];
	assign att_sel   = att_tot_q[idx];
	assign stamp_sel = stamp_q[idx];
	assign mean_sel  = mean_q[idx];
	assign sig_sel   = cmd.sel ? bsig_q : wsig_q;

	assign w_abs      = (wsig_q == lcbhs_pkg::SIG_ABSENT);
	assign b_abs      = (bsig_q == lcbhs_pkg::SIG_ABSENT);
	assign need_score = (mode_q >= lcbhs_pkg::MODE_ADAPT) && !w_abs && !b_abs;

	always_comb begin
		quick = lcbhs_pkg::LINK_WIFI;
		unique case (mode_q)
			lcbhs_pkg::MODE_WIFI: quick = lcbhs_pkg::LINK_WIFI;
			lcbhs_pkg::MODE_BLE: quick = lcbhs_pkg::LINK_BLE;
			lcbhs_pkg::MODE_LAST: begin
				if (stamp_q[0] > stamp_q[1]) begin
					quick = lcbhs_pkg::LINK_WIFI;
				end else begin
					quick = (stamp_q[1] != '0) ? lcbhs_pkg::LINK_BLE
						: lcbhs_pkg::LINK_WIFI;
				end
			end
			lcbhs_pkg::MODE_FAST: begin
				if (mean_q[0] == '0 && mean_q[1] == '0) begin
					quick = lcbhs_pkg::LINK_WIFI;
				end else if (mean_q[0] == '0) begin
					quick = lcbhs_pkg::LINK_BLE;
				end else if (mean_q[1] == '0) begin
					quick = lcbhs_pkg::LINK_WIFI;
				end else begin
					quick = (mean_q[0] < mean_q[1]) ? lcbhs_pkg::LINK_WIFI
						: lcbhs_pkg::LINK_BLE;
				end
			end
			lcbhs_pkg::MODE_STRONG: begin
				if (w_abs && b_abs) begin
					quick = lcbhs_pkg::LINK_WIFI;
				end else begin
					quick = (wsig_q > bsig_q) ? lcbhs_pkg::LINK_WIFI
						: lcbhs_pkg::LINK_BLE;
				end
			end
			default: begin
				quick = (w_abs && !b_abs) ? lcbhs_pkg::LINK_BLE : lcbhs_pkg::LINK_WIFI;
			end
		endcase
	end

	// share numerator 40*s*2^16: top 32 bits stay below attempts
	assign prod40 = {6'b0, succ_sel} * 38'd40;

	lcbhs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.rem_init (prod40[37:6]),
		.low_bits (prod40[5:0]),
		.den      (att_sel),
		.busy     (div_busy),
		.quo      (quo)
	);

	assign age      = now_q - stamp_sel;
	assign sx       = {sig_sel[7], sig_sel} + lcbhs_pkg::SIG_OFFSET;
	assign x7       = sx[6:0];
	assign sig_int  = {15'b0, x7} * {7'b0, lcbhs_pkg::SIG_MUL};
	assign sig_rp   = {12'b0, x7, 2'b0} * {9'b0, lcbhs_pkg::SIG_RMUL};
	assign sig_part = sig_int + {16'b0, sig_rp[lcbhs_pkg::SIG_RSH+5:lcbhs_pkg::SIG_RSH]};
	assign spd_on   = (mean_sel != '0) && (mean_sel < lcbhs_pkg::MEAN_LIMIT);
	assign mean_gap = spd_on ? 14'(lcbhs_pkg::MEAN_LIMIT - mean_sel) : 14'd0;
	assign spd_prod = {21'b0, d67_s1} * {20'b0, lcbhs_pkg::SPD_RCP};

	assign mean_prod = {20'b0, rw_s1} * {20'b0, lcbhs_pkg::MEAN_RCP};
	assign mean_new  = (mean_sel == '0) ? ctime_q
		: mean_prod[lcbhs_pkg::MEAN_SH+15:lcbhs_pkg::MEAN_SH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lcbhs_pkg::MODE_RESET;
		end else if (cfg_wen) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 2; k++) begin
				succ_tot_q[k] <= '0;
				att_tot_q[k]  <= '0;
				stamp_q[k]    <= '0;
				mean_q[k]     <= '0;
			end
		end else if (cmd.clear) begin
			for (int k = 0; k < 2; k++) begin
				succ_tot_q[k] <= '0;
				att_tot_q[k]  <= '0;
				stamp_q[k]    <= '0;
				mean_q[k]     <= '0;
			end
		end else if (cmd.rep_write) begin
			if (att_sel != '1) begin
				att_tot_q[link_q] <= att_sel + 32'd1;
			end
			if (succ_q) begin
				if (succ_sel != '1) begin
					succ_tot_q[link_q] <= succ_sel + 32'd1;
				end
				stamp_q[link_q] <= now_q;
				mean_q[link_q]  <= mean_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q  <= in_kind;
			link_q  <= in_data[0];
			succ_q  <= in_data[1];
			ctime_q <= in_data[17:2];
			wsig_q  <= in_data[18] ? in_data[26:19] : lcbhs_pkg::SIG_ABSENT;
			bsig_q  <= in_data[27] ? in_data[35:28] : lcbhs_pkg::SIG_ABSENT;
			now_q   <= in_data[67:36];
		end
		if (cmd.rep_calc) begin
			rw_s1 <= ({4'b0, ctime_q} * 20'd3) + ({4'b0, mean_sel} * 20'd7);
		end
		if (cmd.term) begin
			if (att_sel == '0) begin
				share_s1 <= '0;
			end else begin
				share_s1 <= (quo > lcbhs_pkg::SHARE_CAP) ? lcbhs_pkg::SHARE_CAP : quo;
			end
			if (stamp_sel == '0) begin
				rec_s1 <= '0;
			end else if (age < lcbhs_pkg::WIN_SHORT) begin
				rec_s1 <= lcbhs_pkg::REC_SHORT;
			end else if (age < lcbhs_pkg::WIN_LONG) begin
				rec_s1 <= lcbhs_pkg::REC_LONG;
			end else begin
				rec_s1 <= '0;
			end
			if (!(sig_sel > lcbhs_pkg::SIG_FLOOR)) begin
				sig_s1 <= '0;
			end else if (sx >= lcbhs_pkg::SIG_KNEE) begin
				sig_s1 <= lcbhs_pkg::SIG_CAP;
			end else begin
				sig_s1 <= sig_part;
			end
			d65_s1 <= {6'b0, mean_gap} * {13'b0, lcbhs_pkg::SPD_MUL};
			d67_s1 <= {6'b0, mean_gap} * {13'b0, lcbhs_pkg::SPD_RES};
		end
		if (cmd.speed) begin
			spd_s2 <= d65_s1 + {7'b0, spd_prod[lcbhs_pkg::SPD_SH+12:lcbhs_pkg::SPD_SH]};
		end
		if (cmd.sum) begin
			score_q[cmd.sel] <= {2'b0, share_s1} + {2'b0, rec_s1} + {2'b0, sig_s1}
				+ {4'b0, spd_s2};
		end
		if (cmd.out_load) begin
			if (need_score) begin
				pick_q <= (score_q[0] >= score_q[1]) ? lcbhs_pkg::LINK_WIFI
					: lcbhs_pkg::LINK_BLE;
			end else begin
				pick_q <= quick;
			end
		end
	end

	assign sts.kind       = kind_q;
	assign sts.need_score = need_score;
	assign sts.div_busy   = div_busy;
	assign pick           = pick_q;

endmodule

@@ rtl/core/lcbhs_ctrl.sv @@
// ----------------------------------------------------------------------------
// Link choice controller
// Sequences capture, report update, clear, score runs and the result register.
// ----------------------------------------------------------------------------
module lcbhs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  lcbhs_pkg::sts_t sts,
	output lcbhs_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_REP_CALC,
		ST_REP_WRITE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_TERM,
		ST_SPEED,
		ST_SUM,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   sel_q;
	logic   out_valid_q;

	always_comb begin
		cmd     = '0;
		cmd.sel = sel_q;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					state_d   = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (sts.kind)
					lcbhs_pkg::KIND_REPORT: state_d = ST_REP_CALC;
					lcbhs_pkg::KIND_SELECT: state_d = sts.need_score ? ST_DIV_START : ST_FINISH;
					lcbhs_pkg::KIND_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = ST_IDLE;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_REP_CALC: begin
				cmd.rep_calc = 1'b1;
				state_d      = ST_REP_WRITE;
			end
			ST_REP_WRITE: begin
				cmd.rep_write = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (!sts.div_busy) begin
					state_d = ST_TERM;
				end
			end
			ST_TERM: begin
				cmd.term = 1'b1;
				state_d  = ST_SPEED;
			end
			ST_SPEED: begin
				cmd.speed = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = (sel_q == lcbhs_pkg::LINK_BLE) ? ST_FINISH : ST_DIV_START;
			end
			ST_FINISH: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= lcbhs_pkg::LINK_WIFI;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DISPATCH) begin
				sel_q <= lcbhs_pkg::LINK_WIFI;
			end else if (state_q == ST_SUM) begin
				sel_q <= lcbhs_pkg::LINK_BLE;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

endmodule
